@@ hdl/vic_pkg.sv @@
// Shared types, register map and helpers for the vectored interrupt controller.
`default_nettype none

package vic_pkg;

  localparam int unsigned NumSources = 32;
  localparam int unsigned TblAw      = (NumSources > 1) ? $clog2(NumSources) : 1;

  localparam logic [31:0] SrcMask = 32'hFFFF_FFFF >> (32 - NumSources);
  localparam logic [5:0]  NoneIdx = 6'd32;

  typedef enum logic [1:0] {
    ReqRead   = 2'd0,
    ReqWrite  = 2'd1,
    ReqSample = 2'd2
  } req_type_e;

  // word offsets of the register map
  localparam logic [6:0] OffStatus    = 7'd0;
  localparam logic [6:0] OffPending   = 7'd1;
  localparam logic [6:0] OffEnable    = 7'd2;
  localparam logic [6:0] OffAck       = 7'd3;
  localparam logic [6:0] OffSetEnable = 7'd4;
  localparam logic [6:0] OffClrEnable = 7'd5;
  localparam logic [6:0] OffVector    = 7'd6;
  localparam logic [6:0] OffMaster    = 7'd7;
  localparam logic [6:0] OffFastMode  = 7'd8;

  typedef struct packed {
    logic             re;
    logic             we;
    logic [TblAw-1:0] waddr;
    logic [31:0]      wdata;
    logic             bus_hit;
    logic [TblAw-1:0] bus_raddr;
    logic [TblAw-1:0] vec_raddr;
  } tbl_req_t;

  // Lowest set bit index, NoneIdx when the word is empty.
  function automatic logic [5:0] lowest_idx(input logic [31:0] p);
    logic [31:0] onehot;
    logic [4:0]  idx;
    onehot = p & (~p + 32'd1);
    idx    = '0;
    for (int i = 0; i < 32; i++) begin
      if (onehot[i]) begin
        idx = idx | 5'(i);
      end
    end
    lowest_idx = (p == '0) ? NoneIdx : {1'b0, idx};
  endfunction

endpackage

`default_nettype wire

@@ hdl/vic_vec_table.sv @@
// Vector table: handler address memory with per-entry valid bits and two read ports.
`default_nettype none

module vic_vec_table (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire vic_pkg::tbl_req_t req_i,
  output logic [31:0]           bus_rdata_o,
  output logic [31:0]           vec_rdata_o
);

  logic [31:0]                   mem [vic_pkg::NumSources];
  logic [vic_pkg::NumSources-1:0] valid_q;
  logic [31:0]                   bus_rdata_q;
  logic [31:0]                   vec_rdata_q;

  // entries read as zero until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      bus_rdata_q <= (req_i.bus_hit && valid_q[req_i.bus_raddr]) ? mem[req_i.bus_raddr] : '0;
      // same-beat write to the selected entry is forwarded
      if (req_i.we && (req_i.waddr == req_i.vec_raddr)) begin
        vec_rdata_q <= req_i.wdata;
      end else begin
        vec_rdata_q <= valid_q[req_i.vec_raddr] ? mem[req_i.vec_raddr] : '0;
      end
    end
  end

  assign bus_rdata_o = bus_rdata_q;
  assign vec_rdata_o = vec_rdata_q;

endmodule

`default_nettype wire

@@ hdl/vectored_interrupt_controller.sv @@
// Vectored interrupt controller top level: register file, priority select and result register.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | req_type_i reg_offset_i write_data_i irq_lines_i
//   out     | output    | out_valid_o/out_ready_i | read_data_o irq_request_o pending_index_o
//           |           |                       | fast_vector_valid_o vector_address_o
//
// One beat per cycle while in_ready_o is high; the result appears in the cycle after acceptance.
// The result register is one deep; in_ready_o drops only while it holds an untaken result.
// State updates and the vector table read happen at the accept edge.
// Reset clears the control registers and out_valid_o; the vector table needs no clearing pass (valid bits).
`default_nettype none

module vectored_interrupt_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [6:0]  reg_offset_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [31:0] irq_lines_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      read_data_o,
  output logic             irq_request_o,
  output logic [5:0]       pending_index_o,
  output logic             fast_vector_valid_o,
  output logic [31:0]      vector_address_o
);

  logic [31:0] status_q, status_d;
  logic [31:0] enable_q, enable_d;
  logic [31:0] fast_q, fast_d;
  logic        master_q, master_d;
  logic        hw_en_q, hw_en_d;

  logic        out_valid_q;
  logic [31:0] rd_csr_q, rd_csr_d;
  logic        rd_tbl_q, rd_tbl_d;
  logic        irq_q, irq_d;
  logic [5:0]  idx_q, idx_d;
  logic        fvv_q, fvv_d;

  logic        accept;
  logic [5:0]  cur_idx;
  logic        is_read, is_write, is_sample;
  logic        tbl_hit;
  logic [31:0] bus_rdata;
  logic [31:0] vec_rdata;

  vic_pkg::tbl_req_t tbl_req;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_read   = (vic_pkg::req_type_e'(req_type_i) == vic_pkg::ReqRead);
  assign is_write  = (vic_pkg::req_type_e'(req_type_i) == vic_pkg::ReqWrite);
  assign is_sample = (vic_pkg::req_type_e'(req_type_i) == vic_pkg::ReqSample);

  // table window is offsets 64..95, limited to implemented sources
  assign tbl_hit = (reg_offset_i[6:5] == 2'b10) &&
                   ({27'd0, reg_offset_i[4:0]} < vic_pkg::NumSources);

  assign cur_idx = vic_pkg::lowest_idx(status_q & enable_q & vic_pkg::SrcMask);

  // register read, from state before this beat
  always_comb begin
    rd_csr_d = '0;
    case (reg_offset_i)
      vic_pkg::OffStatus:   rd_csr_d = status_q;
      vic_pkg::OffPending:  rd_csr_d = status_q & enable_q;
      vic_pkg::OffEnable:   rd_csr_d = enable_q;
      vic_pkg::OffVector:   rd_csr_d = (cur_idx == vic_pkg::NoneIdx) ? '1 : {26'd0, cur_idx};
      vic_pkg::OffMaster:   rd_csr_d = {30'd0, hw_en_q, master_q};
      vic_pkg::OffFastMode: rd_csr_d = fast_q;
      default:              rd_csr_d = '0;
    endcase
    if (!is_read) begin
      rd_csr_d = '0;
    end
    rd_tbl_d = is_read && tbl_hit;
  end

  // state update
  always_comb begin
    status_d = status_q;
    enable_d = enable_q;
    fast_d   = fast_q;
    master_d = master_q;
    hw_en_d  = hw_en_q;
    if (is_write) begin
      case (reg_offset_i)
        vic_pkg::OffStatus: begin
          if (!hw_en_q) begin
            status_d = status_q | (write_data_i & vic_pkg::SrcMask);
          end
        end
        vic_pkg::OffEnable:    enable_d = write_data_i & vic_pkg::SrcMask;
        vic_pkg::OffAck:       status_d = status_q & ~write_data_i;
        vic_pkg::OffSetEnable: enable_d = enable_q | (write_data_i & vic_pkg::SrcMask);
        vic_pkg::OffClrEnable: enable_d = enable_q & ~write_data_i;
        vic_pkg::OffMaster: begin
          master_d = write_data_i[0];
          hw_en_d  = hw_en_q | write_data_i[1];
        end
        vic_pkg::OffFastMode:  fast_d = write_data_i & vic_pkg::SrcMask;
        default: ;
      endcase
    end else if (is_sample && hw_en_q) begin
      status_d = status_q | (irq_lines_i & vic_pkg::SrcMask);
    end
  end

  // result fields reflect state after this beat
  always_comb begin
    idx_d = vic_pkg::lowest_idx(status_d & enable_d & vic_pkg::SrcMask);
    irq_d = master_d && (idx_d != vic_pkg::NoneIdx);
    fvv_d = (idx_d != vic_pkg::NoneIdx) && fast_d[idx_d[4:0]];
  end

  always_comb begin
    tbl_req.re        = accept;
    tbl_req.we        = accept && is_write && tbl_hit;
    tbl_req.waddr     = reg_offset_i[vic_pkg::TblAw-1:0];
    tbl_req.wdata     = write_data_i;
    tbl_req.bus_hit   = tbl_hit;
    tbl_req.bus_raddr = reg_offset_i[vic_pkg::TblAw-1:0];
    tbl_req.vec_raddr = idx_d[vic_pkg::TblAw-1:0];
  end

  vic_vec_table u_vec_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (tbl_req),
    .bus_rdata_o (bus_rdata),
    .vec_rdata_o (vec_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= '0;
      enable_q    <= '0;
      fast_q      <= '0;
      master_q    <= 1'b0;
      hw_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        status_q <= status_d;
        enable_q <= enable_d;
        fast_q   <= fast_d;
        master_q <= master_d;
        hw_en_q  <= hw_en_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_csr_q <= rd_csr_d;
      rd_tbl_q <= rd_tbl_d;
      irq_q    <= irq_d;
      idx_q    <= idx_d;
      fvv_q    <= fvv_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_data_o         = rd_tbl_q ? bus_rdata : rd_csr_q;
  assign irq_request_o       = irq_q;
  assign pending_index_o     = idx_q;
  assign fast_vector_valid_o = fvv_q;
  assign vector_address_o    = fvv_q ? vec_rdata : '0;

  a_irq_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && irq_request_o) |-> (pending_index_o != vic_pkg::NoneIdx))
    else $error("request raised with no pending source");

  a_fast_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fast_vector_valid_o) |-> (pending_index_o != vic_pkg::NoneIdx))
    else $error("fast vector flagged with no pending source");

  a_hw_en_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_en_q |=> hw_en_q)
    else $error("hardware enable cleared after being set");

  a_src_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((status_q | enable_q | fast_q) & ~vic_pkg::SrcMask) == '0)
    else $error("bits set beyond implemented sources");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(pending_index_o)))
    else $error("result register changed while stalled");

endmodule

`default_nettype wire
